// ===== rtl/csreae_pkg.sv =====
// shared types and constants for the csr element access engine
// no dependencies; imported by csr_element_access_engine and its testbench

package csreae_pkg;

  // default store sizes
  localparam int unsigned MAX_ROWS_DEF    = 1024;
  localparam int unsigned MAX_ENTRIES_DEF = 4096;

  // field widths
  localparam int unsigned SLOT_W  = 13;
  localparam int unsigned PTR_W   = 13;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IN_TDATA_W = 80;
  localparam int unsigned ENT_W   = IDX_W + VAL_W;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_MAJOR   = 1'd1;

  // access modes (the unused code acts as get)
  localparam logic [MODE_W-1:0] MODE_GET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD = 2'd2;

  // Q16.16 saturation limits
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

  // commands carried in tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_WR_PTR   = 2'd0,
    CMD_WR_ENTRY = 2'd1,
    CMD_ACCESS   = 2'd2,
    CMD_RD_ENTRY = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RB,
    S_PTR0,
    S_PTR1,
    S_CMP,
    S_CHK,
    S_DONE
  } state_t;

  // saturating Q16.16 add
  function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/csr_element_access_engine.sv =====
// compressed sparse matrix element access engine: stores, search sequencer, output register
// depends on csreae_pkg
//
// channel | dir | handshake                | payload
// in_     | in  | in_tvalid / in_tready    | in_tdata, in_tuser (command), in_tlast
// out_    | out | out_tvalid / out_tready  | out_tdata, out_tuser (found), out_tlast
// cfg_    | in  | cfg_wr_en                | cfg_addr, cfg_wr_data
//
// one item at a time; a write goes straight to S_DONE, a read back in range passes S_RB
// an access passes S_PTR0, S_PTR1, one S_CMP per search step, then S_CHK if the landing
// slot is inside the slice; an empty slice goes from S_PTR1 straight to S_DONE
// the entry memory (one read or write per cycle) sets the search rate
// rst_n is synchronous and clears control state only; store contents are not cleared
// a waiting result sits in the output register while the next beat is taken in

module csr_element_access_engine
  import csreae_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input beats
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // slot[12:0], pointer_value[25:13], row_index[35:26], col_index[45:36],
  // access_value[77:46], zero[79:78]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   in_tlast,
  // result beats
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_value[31:0]
  output logic [VAL_W-1:0]       out_tdata,
  // found[0]
  output logic                   out_tuser,
  output logic                   out_tlast,
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned EW = $clog2(MAX_ENTRIES);
  localparam int unsigned PW = $clog2(MAX_ENTRIES + 1);

  // input field split
  logic [SLOT_W-1:0] in_slot;
  logic [PTR_W-1:0]  in_ptr;
  logic [IDX_W-1:0]  in_row;
  logic [IDX_W-1:0]  in_col;
  logic [VAL_W-1:0]  in_val;
  cmd_t              in_cmd;
  logic              in_accept;

  assign in_slot   = in_tdata[12:0];
  assign in_ptr    = in_tdata[25:13];
  assign in_row    = in_tdata[35:26];
  assign in_col    = in_tdata[45:36];
  assign in_val    = in_tdata[77:46];
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_accept = in_tvalid && in_tready;

  // configuration registers
  logic [MODE_W-1:0] mode_r;
  logic              col_major_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_GET;
      col_major_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_ACCESS_MODE: mode_r      <= cfg_wr_data[MODE_W-1:0];
        CFG_COL_MAJOR:   col_major_r <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // row pointer memory
  logic [PTR_W-1:0] rp_mem [MAX_ROWS+1];
  logic             rp_we;
  logic             rp_re;
  logic [RW-1:0]    rp_addr;
  logic [PTR_W-1:0] rp_rdata_r;

  always_ff @(posedge clk) begin
    if (rp_we) begin
      rp_mem[rp_addr] <= in_ptr;
    end
    if (rp_re) begin
      rp_rdata_r <= rp_mem[rp_addr];
    end
  end

  // entry memory: column index over value
  logic [ENT_W-1:0] ent_mem [MAX_ENTRIES];
  logic             ent_we;
  logic             ent_re;
  logic [EW-1:0]    ent_addr;
  logic [ENT_W-1:0] ent_wdata;
  logic [ENT_W-1:0] ent_rdata_r;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_r <= ent_mem[ent_addr];
    end
  end

  // sequencer and working registers
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  major_r, major_nxt;
  logic [IDX_W-1:0]  minor_r, minor_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              last_r, last_nxt;
  logic [PW-1:0]     lo_r, lo_nxt;
  logic [PW-1:0]     hi_r, hi_nxt;
  logic [PW-1:0]     end_r, end_nxt;
  logic [EW-1:0]     mid_r, mid_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic              res_found_r, res_found_nxt;

  // output register
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_found_r;
  logic              out_last_r;
  logic              load_out;

  // clamped row pointer from the memory read
  logic [31:0]       rp_ext;
  logic [PW-1:0]     rp_clamp;

  assign rp_ext   = 32'(rp_rdata_r);
  assign rp_clamp = (rp_ext > 32'(MAX_ENTRIES)) ? PW'(MAX_ENTRIES) : PW'(rp_ext);

  // search step helpers
  logic [IDX_W-1:0]  rd_col;
  logic [VAL_W-1:0]  rd_val;
  logic              col_lt;
  logic [PW-1:0]     step_lo;
  logic [PW-1:0]     step_hi;
  logic [PW-1:0]     bnd_lo;
  logic [PW-1:0]     bnd_hi;
  logic [PW-1:0]     mid_w;
  logic [IDX_W-1:0]  acc_major;
  logic [IDX_W-1:0]  acc_minor;
  logic [VAL_W-1:0]  upd_val;
  logic              hit;

  assign rd_col    = ent_rdata_r[ENT_W-1:VAL_W];
  assign rd_val    = ent_rdata_r[VAL_W-1:0];
  assign col_lt    = rd_col < minor_r;
  assign step_lo   = col_lt ? (PW'(mid_r) + PW'(1)) : lo_r;
  assign step_hi   = col_lt ? hi_r : PW'(mid_r);
  assign bnd_lo    = (state_r == S_CMP) ? step_lo : lo_r;
  assign bnd_hi    = (state_r == S_CMP) ? step_hi : rp_clamp;
  assign mid_w     = bnd_lo + ((bnd_hi - bnd_lo) >> 1);
  assign acc_major = col_major_r ? in_col : in_row;
  assign acc_minor = col_major_r ? in_row : in_col;
  assign hit       = (rd_col == minor_r);

  // ready only between items
  assign in_tready = (state_r == S_IDLE);

  // value after the update, by mode
  always_comb begin
    case (mode_r)
      MODE_SET: upd_val = val_r;
      MODE_ADD: upd_val = sat_add(rd_val, val_r);
      default:  upd_val = rd_val;
    endcase
  end

  // state register and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_r     <= major_nxt;
    minor_r     <= minor_nxt;
    val_r       <= val_nxt;
    last_r      <= last_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    end_r       <= end_nxt;
    mid_r       <= mid_nxt;
    res_value_r <= res_value_nxt;
    res_found_r <= res_found_nxt;
  end

  // next state, memory controls and results
  always_comb begin
    state_nxt     = state_r;
    major_nxt     = major_r;
    minor_nxt     = minor_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    end_nxt       = end_r;
    mid_nxt       = mid_r;
    res_value_nxt = res_value_r;
    res_found_nxt = res_found_r;
    rp_we         = 1'b0;
    rp_re         = 1'b0;
    rp_addr       = RW'(major_r);
    ent_we        = 1'b0;
    ent_re        = 1'b0;
    ent_addr      = mid_w[EW-1:0];
    ent_wdata     = {rd_col, upd_val};
    load_out      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          val_nxt       = in_val;
          last_nxt      = in_tlast;
          minor_nxt     = acc_minor;
          major_nxt     = acc_major;
          res_value_nxt = '0;
          res_found_nxt = 1'b0;
          state_nxt     = S_DONE;
          unique case (in_cmd)
            CMD_WR_PTR: begin
              rp_addr = RW'(in_slot);
              if (32'(in_slot) <= 32'(MAX_ROWS)) begin
                rp_we         = 1'b1;
                res_value_nxt = VAL_W'(in_ptr);
                res_found_nxt = 1'b1;
              end
            end
            CMD_WR_ENTRY: begin
              ent_addr  = EW'(in_slot);
              ent_wdata = {in_col, in_val};
              if (32'(in_slot) < 32'(MAX_ENTRIES)) begin
                ent_we        = 1'b1;
                res_value_nxt = in_val;
                res_found_nxt = 1'b1;
              end
            end
            CMD_RD_ENTRY: begin
              ent_addr = EW'(in_slot);
              if (32'(in_slot) < 32'(MAX_ENTRIES)) begin
                ent_re    = 1'b1;
                state_nxt = S_RB;
              end
            end
            CMD_ACCESS: begin
              rp_addr = RW'(acc_major);
              if (32'(acc_major) < 32'(MAX_ROWS)) begin
                rp_re     = 1'b1;
                state_nxt = S_PTR0;
              end
            end
            default: ;
          endcase
        end
      end
      // read back data has arrived
      S_RB: begin
        res_value_nxt = rd_val;
        res_found_nxt = 1'b1;
        state_nxt     = S_DONE;
      end
      // slice start arrives, fetch slice end
      S_PTR0: begin
        lo_nxt    = rp_clamp;
        rp_addr   = RW'(32'(major_r) + 32'd1);
        rp_re     = 1'b1;
        state_nxt = S_PTR1;
      end
      // slice end arrives, start the search or give a miss
      S_PTR1: begin
        end_nxt = rp_clamp;
        hi_nxt  = rp_clamp;
        if (lo_r < rp_clamp) begin
          mid_nxt   = mid_w[EW-1:0];
          ent_re    = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // one lower-bound step per cycle
      S_CMP: begin
        lo_nxt = step_lo;
        hi_nxt = step_hi;
        if (step_lo < step_hi) begin
          mid_nxt = mid_w[EW-1:0];
          ent_re  = 1'b1;
        end else if (step_lo < end_r) begin
          ent_addr  = step_lo[EW-1:0];
          ent_re    = 1'b1;
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // check the landing slot and, on a hit in set or add mode, write back the update
      S_CHK: begin
        ent_addr = lo_r[EW-1:0];
        if (hit) begin
          res_value_nxt = upd_val;
          res_found_nxt = 1'b1;
          ent_we        = (mode_r == MODE_SET) || (mode_r == MODE_ADD);
        end
        state_nxt = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value_r <= res_value_r;
      out_found_r <= res_found_r;
      out_last_r  <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  // checks
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("beat accepted while another is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before it was taken");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r <= PW'(mid_r) && PW'(mid_r) < hi_r && hi_r <= end_r))
    else $error("search window out of order");

  a_update_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && ent_we) |-> hit)
    else $error("entry written back without a column match");

endmodule

// ===== sim/tb_csr_element_access_engine.sv =====
// self-checking testbench for csr_element_access_engine: random load, access and read-back beats
// checked against a predictor kept in step with the stores; depends on csreae_pkg and the rtl

module tb_csr_element_access_engine;
  import csreae_pkg::*;

  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned N_ROWS     = MAX_ROWS_DEF;
  localparam int unsigned N_ENT      = MAX_ENTRIES_DEF;
  localparam int unsigned N_PHASES   = 8;

  // the spare mode code behaves as get
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // per phase register settings
  localparam logic [MODE_W-1:0] PHASE_MODE [N_PHASES] =
    '{MODE_GET, MODE_SET, MODE_ADD, MODE_SPARE, MODE_ADD, MODE_SET, MODE_GET, MODE_ADD};
  localparam bit PHASE_COLS [N_PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic [PTR_W-1:0]  ptr;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VAL_W-1:0]  value;
    logic              last;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             found;
    logic             last;
  } result_t;

  typedef struct packed {
    request_t req;
    result_t  want;
    logic     hold;
  } queued_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [VAL_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  // predictor state: stores, which entries were loaded, register copies
  logic [PTR_W-1:0] shadow_ptr [0:N_ROWS];
  logic [IDX_W-1:0] shadow_col [0:N_ENT-1];
  logic [VAL_W-1:0] shadow_val [0:N_ENT-1];
  bit               ptr_loaded [0:N_ROWS];
  bit               entry_loaded [0:N_ENT-1];
  int unsigned      loaded_slots [$];
  int unsigned      live_majors [$];
  logic [MODE_W-1:0] mode_reg = MODE_GET;
  bit               by_cols = 1'b0;

  queued_t     pending_requests [$];
  result_t     awaited_results [$];
  queued_t     on_bus;
  result_t     want;
  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  csr_element_access_engine i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic int unsigned clamp_ptr(input logic [PTR_W-1:0] p);
    return (p > N_ENT) ? N_ENT : int'(p);
  endfunction

  function automatic logic [VAL_W-1:0] q16_add_sat(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
    longint sum;
    sum = longint'($signed(a)) + longint'($signed(b));
    if (sum > longint'($signed(VAL_MAX))) return VAL_MAX;
    if (sum < longint'($signed(VAL_MIN))) return VAL_MIN;
    return sum[VAL_W-1:0];
  endfunction

  // lower-bound search of one slice; clean is low if any store read hits an unloaded slot
  function automatic logic slice_find(input int unsigned major, input int unsigned minor,
                                      output int unsigned pos, output logic clean);
    int unsigned lo, hi, stop, mid;
    pos = 0;
    clean = ptr_loaded[major] && ptr_loaded[major + 1];
    if (!clean) return 1'b0;
    lo = clamp_ptr(shadow_ptr[major]);
    stop = clamp_ptr(shadow_ptr[major + 1]);
    hi = stop;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!entry_loaded[mid]) clean = 1'b0;
      if (shadow_col[mid] < minor) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    if (lo < stop) begin
      if (!entry_loaded[lo]) clean = 1'b0;
      return shadow_col[lo] == minor;
    end
    return 1'b0;
  endfunction

  // expected result of one request, updating the shadow stores
  function automatic result_t matrix_apply(input request_t rq);
    result_t     r;
    int unsigned pos, major, minor;
    logic        clean;
    r.value = '0;
    r.found = 1'b0;
    r.last = rq.last;
    case (rq.cmd)
      CMD_WR_PTR: begin
        if (rq.slot <= N_ROWS) begin
          shadow_ptr[rq.slot] = rq.ptr;
          ptr_loaded[rq.slot] = 1'b1;
          r.value = VAL_W'(rq.ptr);
          r.found = 1'b1;
        end
      end
      CMD_WR_ENTRY: begin
        if (rq.slot < N_ENT) begin
          if (!entry_loaded[rq.slot]) loaded_slots.push_back(rq.slot);
          entry_loaded[rq.slot] = 1'b1;
          shadow_col[rq.slot] = rq.col;
          shadow_val[rq.slot] = rq.value;
          r.value = rq.value;
          r.found = 1'b1;
        end
      end
      CMD_RD_ENTRY: begin
        if (rq.slot < N_ENT) begin
          r.value = shadow_val[rq.slot];
          r.found = 1'b1;
        end
      end
      default: begin
        // a 10-bit major index is always below the row count
        major = by_cols ? rq.col : rq.row;
        minor = by_cols ? rq.row : rq.col;
        if (slice_find(major, minor, pos, clean)) begin
          if (mode_reg == MODE_SET) shadow_val[pos] = rq.value;
          else if (mode_reg == MODE_ADD) shadow_val[pos] = q16_add_sat(shadow_val[pos], rq.value);
          r.value = shadow_val[pos];
          r.found = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(7, 0))
      0: return VAL_MAX;
      1: return VAL_MIN;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t random_request(input cmd_t c);
    request_t rq;
    rq.cmd = c;
    rq.slot = SLOT_W'($urandom);
    rq.ptr = PTR_W'($urandom);
    rq.row = IDX_W'($urandom);
    rq.col = IDX_W'($urandom);
    rq.value = random_value();
    rq.last = 1'($urandom_range(1, 0));
    return rq;
  endfunction

  task automatic emit(input request_t rq, input logic hold);
    queued_t q;
    q.req = rq;
    q.want = matrix_apply(rq);
    q.hold = hold;
    pending_requests.push_back(q);
    issued_count++;
  endtask

  task automatic put(input cmd_t c, input int unsigned slot, input int unsigned ptr,
                     input int unsigned row, input int unsigned col,
                     input logic [VAL_W-1:0] value, input logic hold);
    request_t rq;
    rq = random_request(c);
    rq.slot = SLOT_W'(slot);
    rq.ptr = PTR_W'(ptr);
    rq.row = IDX_W'(row);
    rq.col = IDX_W'(col);
    rq.value = value;
    emit(rq, hold);
  endtask

  // a run of consecutive slices with sorted columns, placed at a random row and offset
  task automatic load_slices();
    int unsigned n, base, cursor, c, k, e, cnt;
    request_t    rq;
    n = $urandom_range(8, 1);
    base = $urandom_range(N_ROWS - n, 0);
    if ($urandom_range(9, 0) == 0) cursor = $urandom_range(N_ENT - 1, N_ENT - 24);
    else cursor = $urandom_range(N_ENT - 64, 0);
    for (k = 0; k <= n; k++) begin
      rq = random_request(CMD_WR_PTR);
      rq.slot = SLOT_W'(base + k);
      rq.ptr = PTR_W'(cursor);
      emit(rq, 1'b0);
      if (k < n) begin
        cnt = $urandom_range(6, 0);
        c = $urandom_range(255, 0);
        for (e = 0; e < cnt && c < 1024; e++) begin
          rq = random_request(CMD_WR_ENTRY);
          rq.slot = SLOT_W'(cursor);
          rq.col = IDX_W'(c);
          emit(rq, 1'b0);
          cursor++;
          c += $urandom_range(200, 1);
        end
        live_majors.push_back(base + k);
        if (live_majors.size() > 64) void'(live_majors.pop_front());
      end
    end
  endtask

  // access beat on a loaded slice, mostly aimed at a stored column; wild picks any index
  task automatic access_element(input bit wild);
    request_t    rq;
    int unsigned major, minor, lo, stop, pos, tries;
    logic        clean;
    for (tries = 0; tries < 8; tries++) begin
      if (wild || live_majors.size() == 0) major = $urandom_range(N_ROWS - 1, 0);
      else major = live_majors[$urandom_range(live_majors.size() - 1, 0)];
      minor = $urandom_range(1023, 0);
      if (!wild && ptr_loaded[major] && ptr_loaded[major + 1]) begin
        lo = clamp_ptr(shadow_ptr[major]);
        stop = clamp_ptr(shadow_ptr[major + 1]);
        if (lo < stop && $urandom_range(9, 0) < 7) begin
          pos = $urandom_range(stop - 1, lo);
          if (entry_loaded[pos]) minor = shadow_col[pos];
        end
      end
      void'(slice_find(major, minor, pos, clean));
      if (clean) begin
        rq = random_request(CMD_ACCESS);
        rq.row = IDX_W'(by_cols ? minor : major);
        rq.col = IDX_W'(by_cols ? major : minor);
        emit(rq, $urandom_range(199, 0) == 0);
        return;
      end
    end
  endtask

  task automatic read_entry(input bit wild);
    request_t rq;
    rq = random_request(CMD_RD_ENTRY);
    if (wild || loaded_slots.size() == 0) rq.slot = SLOT_W'($urandom_range(8191, N_ENT));
    else rq.slot = SLOT_W'(loaded_slots[$urandom_range(loaded_slots.size() - 1, 0)]);
    emit(rq, 1'b0);
  endtask

  task automatic random_phase(input int unsigned budget);
    int unsigned goal, pick;
    goal = issued_count + budget;
    while (issued_count < goal) begin
      pick = $urandom_range(99, 0);
      if (pick < 12) load_slices();
      else if (pick < 72) access_element(1'b0);
      else if (pick < 82) read_entry(1'b0);
      else if (pick < 86) read_entry(1'b1);
      else if (pick < 90) emit(random_request(CMD_WR_PTR), 1'b0);
      else if (pick < 94) emit(random_request(CMD_WR_ENTRY), 1'b0);
      else access_element(1'b1);
    end
  endtask

  // input driver: holds a beat until taken, a held request waits for all results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(on_bus.want);
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct &&
            !(pending_requests[0].hold && awaited_results.size() != 0)) begin
          on_bus = pending_requests.pop_front();
          // slot, pointer, row, col, value from bit 0 up, zero pad on top
          in_tdata <= {2'b00, on_bus.req.value, on_bus.req.col, on_bus.req.row,
                       on_bus.req.ptr, on_bus.req.slot};
          in_tuser <= on_bus.req.cmd;
          in_tlast <= on_bus.req.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each taken beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: value=%h found=%b last=%b",
                   $time, out_tdata, out_tuser, out_tlast);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata !== want.value || out_tuser !== want.found || out_tlast !== want.last) begin
            $display("%0t: mismatch expected value=%h found=%b last=%b, actual value=%h found=%b last=%b",
                     $time, want.value, want.found, want.last, out_tdata, out_tuser, out_tlast);
            err_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // phase sequencing: registers change only once the block has drained
  initial begin
    int unsigned ph;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 52;
      end else if (ph < 6) begin
        send_idle_pct = 52;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr <= CFG_ACCESS_MODE;
      cfg_wr_data <= PHASE_MODE[ph];
      @(posedge clk);
      cfg_addr <= CFG_COL_MAJOR;
      cfg_wr_data <= {1'($urandom_range(1, 0)), PHASE_COLS[ph]};
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      mode_reg = PHASE_MODE[ph];
      by_cols = PHASE_COLS[ph];
      if (ph == 0) begin
        // small matrix: row 0 three entries, row 1 empty, row 2 two entries,
        // row 3 start above end, row 1023 end pointer past the entry store
        put(CMD_WR_PTR, 0, 0, 0, 0, '0, 1'b0);
        put(CMD_WR_PTR, 1, 3, 0, 0, '0, 1'b0);
        put(CMD_WR_PTR, 2, 3, 0, 0, '0, 1'b0);
        put(CMD_WR_PTR, 3, 5, 0, 0, '0, 1'b0);
        put(CMD_WR_PTR, 4, 2, 0, 0, '0, 1'b0);
        put(CMD_WR_PTR, 1023, 4095, 0, 0, '0, 1'b0);
        put(CMD_WR_PTR, 1024, 8191, 0, 0, '0, 1'b0);
        put(CMD_WR_PTR, 8191, 8191, 1023, 1023, VAL_MAX, 1'b0);
        put(CMD_WR_ENTRY, 0, 0, 0, 5, VAL_MAX, 1'b0);
        put(CMD_WR_ENTRY, 1, 0, 0, 100, VAL_MIN, 1'b0);
        put(CMD_WR_ENTRY, 2, 0, 0, 1023, 32'h0001_0000, 1'b0);
        put(CMD_WR_ENTRY, 3, 0, 0, 0, 32'hffff_ffff, 1'b0);
        put(CMD_WR_ENTRY, 4, 0, 0, 7, '0, 1'b0);
        put(CMD_WR_ENTRY, 4095, 0, 0, 1023, 32'h5555_aaaa, 1'b0);
        put(CMD_WR_ENTRY, 8191, 8191, 1023, 1023, VAL_MAX, 1'b0);
        // hits, a miss inside a slice, empty and inverted slices, clamped end
        put(CMD_ACCESS, 0, 0, 0, 100, 32'h0000_0001, 1'b1);
        put(CMD_ACCESS, 0, 0, 0, 6, VAL_MAX, 1'b0);
        put(CMD_ACCESS, 0, 0, 0, 1023, VAL_MIN, 1'b0);
        put(CMD_ACCESS, 0, 0, 1, 5, VAL_MAX, 1'b0);
        put(CMD_ACCESS, 0, 0, 2, 7, 32'h7fff_0000, 1'b0);
        put(CMD_ACCESS, 0, 0, 3, 0, VAL_MIN, 1'b0);
        put(CMD_ACCESS, 0, 0, 1023, 1023, VAL_MAX, 1'b0);
        put(CMD_RD_ENTRY, 4095, 0, 0, 0, '0, 1'b0);
        put(CMD_RD_ENTRY, 4096, 0, 0, 0, '0, 1'b0);
        put(CMD_RD_ENTRY, 8191, 8191, 1023, 1023, VAL_MAX, 1'b0);
      end
      random_phase(200);
      do @(posedge clk);
      while (accepted_count != issued_count || awaited_results.size() != 0);
      repeat (4) @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * 600000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
